/* rtl/obcd_pkg.sv */
// ----------------------------------------------------------------------------
// obcd_pkg
// Shared types, register indexes and lookup tables of the oriented box decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package obcd_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_PAD_LEFT        = 3'd1,
        REG_PAD_TOP         = 3'd2,
        REG_INVERSE_SCALE   = 3'd3,
        REG_FRAME_WIDTH     = 3'd4,
        REG_FRAME_HEIGHT    = 3'd5,
        REG_CLASSES_IN_USE  = 3'd6
    } cfg_reg_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SIG   = 7'b0000010,
        ST_TRIG  = 7'b0000100,
        ST_ROT   = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    localparam logic KIND_LOGIT = 1'b0;
    localparam logic KIND_GEOM  = 1'b1;

    typedef struct packed {
        logic class_upd;
        logic geom_load;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic seen;
        logic pass;
        logic out_busy;
    } dp_status_t;

    // sigmoid, Q0.16, steps of 0.5 in the logit
    function automatic logic [15:0] sig_tab(input logic [5:0] i);
        logic [15:0] v;
        case (i)
            6'd0:  v = 16'd32768;
            6'd1:  v = 16'd40793;
            6'd2:  v = 16'd47911;
            6'd3:  v = 16'd53581;
            6'd4:  v = 16'd57724;
            6'd5:  v = 16'd60565;
            6'd6:  v = 16'd62428;
            6'd7:  v = 16'd63615;
            6'd8:  v = 16'd64357;
            6'd9:  v = 16'd64816;
            6'd10: v = 16'd65097;
            6'd11: v = 16'd65269;
            6'd12: v = 16'd65374;
            6'd13: v = 16'd65438;
            6'd14: v = 16'd65476;
            6'd15: v = 16'd65500;
            6'd16: v = 16'd65514;
            6'd17: v = 16'd65523;
            6'd18: v = 16'd65528;
            6'd19: v = 16'd65531;
            6'd20: v = 16'd65533;
            6'd21: v = 16'd65534;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    // quarter-wave sine, Q1.14
    function automatic logic [14:0] sin_tab(input logic [4:0] i);
        logic [14:0] v;
        case (i)
            5'd0:  v = 15'd0;
            5'd1:  v = 15'd1606;
            5'd2:  v = 15'd3196;
            5'd3:  v = 15'd4756;
            5'd4:  v = 15'd6270;
            5'd5:  v = 15'd7723;
            5'd6:  v = 15'd9102;
            5'd7:  v = 15'd10394;
            5'd8:  v = 15'd11585;
            5'd9:  v = 15'd12665;
            5'd10: v = 15'd13623;
            5'd11: v = 15'd14449;
            5'd12: v = 15'd15137;
            5'd13: v = 15'd15679;
            5'd14: v = 15'd16069;
            5'd15: v = 15'd16305;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/obcd_ctrl.sv */
// ----------------------------------------------------------------------------
// obcd_ctrl
// Sequencer: takes items, steps the geometry datapath, loads the result.
// ----------------------------------------------------------------------------
`default_nettype none

module obcd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  kind,
    output logic                       in_stall,
    input  wire obcd_pkg::dp_status_t  status,
    output obcd_pkg::dp_cmd_t          cmd
);

    obcd_pkg::state_t state_reg, state_next;
    logic take;

    assign in_stall = (state_reg != obcd_pkg::ST_IDLE);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        state_next    = state_reg;
        cmd.class_upd = 1'b0;
        cmd.geom_load = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            obcd_pkg::ST_IDLE:
            begin
                if (take && kind == obcd_pkg::KIND_LOGIT)
                begin
                    cmd.class_upd = 1'b1;
                end
                else if (take)
                begin
                    cmd.geom_load = 1'b1;
                    if (status.seen)
                        state_next = obcd_pkg::ST_SIG;
                end
            end
            obcd_pkg::ST_SIG:   state_next = obcd_pkg::ST_TRIG;
            obcd_pkg::ST_TRIG:
                state_next = status.pass ? obcd_pkg::ST_ROT : obcd_pkg::ST_IDLE;
            obcd_pkg::ST_ROT:   state_next = obcd_pkg::ST_SUM;
            obcd_pkg::ST_SUM:   state_next = obcd_pkg::ST_SCALE;
            obcd_pkg::ST_SCALE: state_next = obcd_pkg::ST_FIN;
            obcd_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = obcd_pkg::ST_IDLE;
                end
            end
            default: state_next = obcd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= obcd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/obcd_datapath.sv */
// ----------------------------------------------------------------------------
// obcd_datapath
// Config registers, running argmax, and the staged geometry arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module obcd_datapath #(
    parameter int MAX_CLASSES = 255,
    parameter int MAX_GRID    = 512
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire obcd_pkg::dp_cmd_t                 cmd,
    output obcd_pkg::dp_status_t                   status,
    input  wire logic                              cfg_valid,
    input  wire logic [obcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [15:0]                       cfg_data,
    input  wire logic signed [15:0]                class_logit,
    input  wire logic signed [15:0]                dist_left,
    input  wire logic signed [15:0]                dist_top,
    input  wire logic signed [15:0]                dist_right,
    input  wire logic signed [15:0]                dist_bottom,
    input  wire logic signed [15:0]                angle,
    input  wire logic [8:0]                        cell_col,
    input  wire logic [8:0]                        cell_row,
    input  wire logic [1:0]                        stride_code,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [15:0]                            center_x,
    output logic [15:0]                            center_y,
    output logic [16:0]                            box_width,
    output logic [16:0]                            box_height,
    output logic signed [15:0]                     box_angle,
    output logic [7:0]                             class_index,
    output logic [15:0]                            confidence
);

    // ---------------- configuration ----------------
    logic [15:0] thr_reg;
    logic [11:0] pad_l_reg, pad_t_reg;
    logic [15:0] inv_reg;
    logic [12:0] fw_reg, fh_reg;
    logic [7:0]  ciu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= 16'd16384;
            pad_l_reg <= 12'd0;
            pad_t_reg <= 12'd0;
            inv_reg   <= 16'd4096;
            fw_reg    <= 13'd640;
            fh_reg    <= 13'd640;
            ciu_reg   <= 8'd15;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                obcd_pkg::REG_SCORE_THRESHOLD: thr_reg   <= cfg_data;
                obcd_pkg::REG_PAD_LEFT:        pad_l_reg <= cfg_data[11:0];
                obcd_pkg::REG_PAD_TOP:         pad_t_reg <= cfg_data[11:0];
                obcd_pkg::REG_INVERSE_SCALE:   inv_reg   <= cfg_data;
                obcd_pkg::REG_FRAME_WIDTH:     fw_reg    <= cfg_data[12:0];
                obcd_pkg::REG_FRAME_HEIGHT:    fh_reg    <= cfg_data[12:0];
                obcd_pkg::REG_CLASSES_IN_USE:  ciu_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- running argmax ----------------
    logic signed [15:0] best_logit_reg;
    logic [7:0]         best_class_reg, class_cnt_reg;
    logic               seen_reg;
    logic [7:0]         limit;

    assign limit = (ciu_reg < 8'(MAX_CLASSES)) ? ciu_reg : 8'(MAX_CLASSES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_logit_reg <= '0;
            best_class_reg <= '0;
            class_cnt_reg  <= '0;
            seen_reg       <= 1'b0;
        end
        else if (cmd.geom_load)
        begin
            best_logit_reg <= '0;
            best_class_reg <= '0;
            class_cnt_reg  <= '0;
            seen_reg       <= 1'b0;
        end
        else if (cmd.class_upd && class_cnt_reg < limit)
        begin
            if (!seen_reg || class_logit > best_logit_reg)
            begin
                best_logit_reg <= class_logit;
                best_class_reg <= class_cnt_reg;
            end
            seen_reg      <= 1'b1;
            class_cnt_reg <= class_cnt_reg + 8'd1;
        end
    end

    // ---------------- geometry capture ----------------
    logic signed [15:0] g_logit_reg, g_l_reg, g_t_reg, g_r_reg, g_b_reg, g_ang_reg;
    logic [7:0]         g_class_reg;
    logic [8:0]         g_col_reg, g_row_reg;
    logic [2:0]         g_sh_reg;   // log2 of stride
    logic [2:0]         sh_in;

    always_comb
    begin
        case (stride_code)
            2'd0:    sh_in = 3'd3;
            2'd1:    sh_in = 3'd4;
            default: sh_in = 3'd5;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.geom_load)
        begin
            g_logit_reg <= best_logit_reg;
            g_class_reg <= best_class_reg;
            g_l_reg     <= dist_left;
            g_t_reg     <= dist_top;
            g_r_reg     <= dist_right;
            g_b_reg     <= dist_bottom;
            g_ang_reg   <= angle;
            g_col_reg   <= (cell_col > 9'(MAX_GRID - 1)) ? 9'(MAX_GRID - 1) : cell_col;
            g_row_reg   <= (cell_row > 9'(MAX_GRID - 1)) ? 9'(MAX_GRID - 1) : cell_row;
            g_sh_reg    <= sh_in;
        end
    end

    // ---------------- stage 1: sigmoid, phase, distances ----------------
    logic signed [16:0] lx;
    logic [16:0]        la;
    logic [15:0]        st0, st1, sdiff;
    logic [25:0]        sprod;
    logic [16:0]        sval, conf_full;
    logic signed [33:0] ang_prod;
    logic signed [16:0] dx17, dy17, ws17, hs17;

    logic [15:0]        conf_reg;
    logic [17:0]        phase_reg;
    logic signed [21:0] d_reg, e_reg, wsum_reg, hsum_reg;

    always_comb
    begin
        lx    = 17'(g_logit_reg);
        la    = lx[16] ? 17'(-lx) : 17'(lx);
        st0   = obcd_pkg::sig_tab(la[15:10]);
        st1   = obcd_pkg::sig_tab(la[15:10] + 6'd1);
        sdiff = st1 - st0;
        sprod = sdiff * la[9:0];
        sval  = (la[15:10] == 6'd32) ? {1'b0, st0} : 17'(st0) + 17'(sprod[25:10]);
        conf_full = lx[16] ? (17'd65536 - sval) : sval;
        ang_prod  = 34'(g_ang_reg) * 34'sd41722;
        dx17 = 17'(g_r_reg) - 17'(g_l_reg);
        dy17 = 17'(g_b_reg) - 17'(g_t_reg);
        ws17 = 17'(g_l_reg) + 17'(g_r_reg);
        hs17 = 17'(g_t_reg) + 17'(g_b_reg);
    end

    always_ff @(posedge clk)
    begin
        conf_reg  <= conf_full[15:0];
        phase_reg <= ang_prod[30:13];
        d_reg     <= 22'(dx17) <<< g_sh_reg;
        e_reg     <= 22'(dy17) <<< g_sh_reg;
        wsum_reg  <= 22'(ws17) <<< g_sh_reg;
        hsum_reg  <= 22'(hs17) <<< g_sh_reg;
    end

    // ---------------- stage 2: sine and cosine ----------------
    function automatic logic [14:0] quarter_sin(input logic [16:0] f);
        logic [14:0] t0, t1, df;
        logic [26:0] pr;
        t0 = obcd_pkg::sin_tab(f[16:12]);
        t1 = obcd_pkg::sin_tab(f[16:12] + 5'd1);
        df = t1 - t0;
        pr = df * f[11:0];
        if (f[16:12] == 5'd16)
            return t0;
        return t0 + pr[26:12];
    endfunction

    function automatic logic signed [15:0] phase_sin(input logic [17:0] p);
        logic [16:0] arg;
        logic [14:0] m;
        arg = p[16] ? (17'd65536 - {1'b0, p[15:0]}) : {1'b0, p[15:0]};
        m   = quarter_sin(arg);
        return p[17] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    logic signed [15:0] sin_reg, cos_reg;

    always_ff @(posedge clk)
    begin
        sin_reg <= phase_sin(phase_reg);
        cos_reg <= phase_sin(phase_reg + 18'd65536);
    end

    // ---------------- stage 3: rotation and size products ----------------
    logic signed [37:0] dc_reg, es_reg, ds_reg, ec_reg;
    logic signed [38:0] wsc_reg, hsc_reg;

    always_ff @(posedge clk)
    begin
        dc_reg  <= d_reg * cos_reg;
        es_reg  <= e_reg * sin_reg;
        ds_reg  <= d_reg * sin_reg;
        ec_reg  <= e_reg * cos_reg;
        wsc_reg <= 39'(wsum_reg) * $signed({23'b0, inv_reg});
        hsc_reg <= 39'(hsum_reg) * $signed({23'b0, inv_reg});
    end

    // ---------------- stage 4: offset, cell center, pad ----------------
    logic signed [38:0] rx_full, ry_full, rx_sh, ry_sh;
    logic [17:0]        ccx, ccy;
    logic signed [20:0] px_reg, py_reg;

    always_comb
    begin
        rx_full = 39'(dc_reg) - 39'(es_reg) + 39'sd262144;
        ry_full = 39'(ds_reg) + 39'(ec_reg) + 39'sd262144;
        rx_sh   = rx_full >>> 19;
        ry_sh   = ry_full >>> 19;
        // shift reaches 8 at stride 32, so the amount needs four bits
        ccx     = 18'({g_col_reg, 1'b1}) << (4'(g_sh_reg) + 4'd3);
        ccy     = 18'({g_row_reg, 1'b1}) << (4'(g_sh_reg) + 4'd3);
    end

    always_ff @(posedge clk)
    begin
        px_reg <= $signed({3'b0, ccx}) + 21'(rx_sh) - $signed({5'b0, pad_l_reg, 4'b0});
        py_reg <= $signed({3'b0, ccy}) + 21'(ry_sh) - $signed({5'b0, pad_t_reg, 4'b0});
    end

    // ---------------- stage 5: scale ----------------
    logic signed [37:0] pxs_reg, pys_reg;

    always_ff @(posedge clk)
    begin
        pxs_reg <= 38'(px_reg) * $signed({22'b0, inv_reg});
        pys_reg <= 38'(py_reg) * $signed({22'b0, inv_reg});
    end

    // ---------------- final: round and clamp ----------------
    logic [12:0]        fwc, fhc;
    logic signed [37:0] cx_r, cy_r, cx_hi, cy_hi;
    logic signed [38:0] w_r, h_r, w_hi, h_hi;
    logic [15:0]        cx_o, cy_o;
    logic [16:0]        w_o, h_o;

    always_comb
    begin
        fwc = (fw_reg == 13'd0) ? 13'd1 : ((fw_reg > 13'd4096) ? 13'd4096 : fw_reg);
        fhc = (fh_reg == 13'd0) ? 13'd1 : ((fh_reg > 13'd4096) ? 13'd4096 : fh_reg);
        cx_r  = (pxs_reg + 38'sd2048) >>> 12;
        cy_r  = (pys_reg + 38'sd2048) >>> 12;
        cx_hi = $signed({21'b0, fwc - 13'd1, 4'b0});
        cy_hi = $signed({21'b0, fhc - 13'd1, 4'b0});
        w_r   = (wsc_reg + 39'sd32768) >>> 16;
        h_r   = (hsc_reg + 39'sd32768) >>> 16;
        w_hi  = $signed({22'b0, fwc, 4'b0});
        h_hi  = $signed({22'b0, fhc, 4'b0});
        cx_o  = (cx_r < 0) ? 16'd0 : ((cx_r > cx_hi) ? cx_hi[15:0] : cx_r[15:0]);
        cy_o  = (cy_r < 0) ? 16'd0 : ((cy_r > cy_hi) ? cy_hi[15:0] : cy_r[15:0]);
        w_o   = (w_r < 39'sd16) ? 17'd16 : ((w_r > w_hi) ? w_hi[16:0] : w_r[16:0]);
        h_o   = (h_r < 39'sd16) ? 17'd16 : ((h_r > h_hi) ? h_hi[16:0] : h_r[16:0]);
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            center_x    <= cx_o;
            center_y    <= cy_o;
            box_width   <= w_o;
            box_height  <= h_o;
            box_angle   <= g_ang_reg;
            class_index <= g_class_reg;
            confidence  <= conf_reg;
        end
    end

    assign status.seen     = seen_reg;
    assign status.pass     = (conf_reg >= thr_reg);
    assign status.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

/* rtl/oriented_box_cell_decode_unit.sv */
// Logit requests: one per cycle, back to back. A geometry request holds the input through
// accept, sigmoid, trig, rotate, sum, scale and clamp; below threshold it ends after trig,
// with no class after accept. The result is loaded from clamp; the clamp step holds while
// the previous result still waits in the output register.
// rst_n (async, active low) clears the sequencer, cell state and output valid and
// loads the register defaults.
// ----------------------------------------------------------------------------
// oriented_box_cell_decode_unit
// Top level: one grid cell of an oriented box detector head to at most one detection.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_box_cell_decode_unit #(
    parameter int MAX_CLASSES = 255,
    parameter int MAX_GRID    = 512
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              kind,
    input  wire logic signed [15:0]                class_logit,
    input  wire logic signed [15:0]                dist_left,
    input  wire logic signed [15:0]                dist_top,
    input  wire logic signed [15:0]                dist_right,
    input  wire logic signed [15:0]                dist_bottom,
    input  wire logic signed [15:0]                angle,
    input  wire logic [8:0]                        cell_col,
    input  wire logic [8:0]                        cell_row,
    input  wire logic [1:0]                        stride_code,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [15:0]                            center_x,
    output logic [15:0]                            center_y,
    output logic [16:0]                            box_width,
    output logic [16:0]                            box_height,
    output logic signed [15:0]                     box_angle,
    output logic [7:0]                             class_index,
    output logic [15:0]                            confidence,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [obcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [15:0]                       cfg_data
);

    obcd_pkg::dp_cmd_t    cmd;
    obcd_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    obcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    obcd_datapath #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_GRID    (MAX_GRID)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .class_logit (class_logit),
        .dist_left   (dist_left),
        .dist_top    (dist_top),
        .dist_right  (dist_right),
        .dist_bottom (dist_bottom),
        .angle       (angle),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .stride_code (stride_code),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .center_x    (center_x),
        .center_y    (center_y),
        .box_width   (box_width),
        .box_height  (box_height),
        .box_angle   (box_angle),
        .class_index (class_index),
        .confidence  (confidence)
    );

endmodule

`default_nettype wire

/* rtl/obcd_checker.sv */
// ----------------------------------------------------------------------------
// obcd_checker
// Port-level checks on the oriented box decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obcd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic kind,
    input wire logic out_valid,
    input wire logic out_stall
);

    // a waiting result is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // logit requests never stall the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == 1'b0 |=> !in_stall)
        else $error("stall after logit request");

    // a new result only appears once the input has been held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without geometry processing");

    // no result can appear the cycle right after a geometry request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == 1'b1 |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind oriented_box_cell_decode_unit obcd_checker u_obcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

`default_nettype wire

/* bench/oriented_box_cell_decode_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oriented_box_cell_decode_unit_tb
// Checks decoded detections against a behavioral predictor. Directed corner
// cells, then random cells with random request gaps, output stalls and
// register settings changed between phases.
// ----------------------------------------------------------------------------

module oriented_box_cell_decode_unit_tb;

    typedef struct packed {
        logic        kind;
        logic [15:0] logit;
        logic [15:0] dl, dt, dr, db, ang;
        logic [8:0]  col, row;
        logic [1:0]  sc;
    } cell_req_t;

    typedef struct packed {
        logic [15:0] cx, cy;
        logic [16:0] bw, bh;
        logic [15:0] ang;
        logic [7:0]  cls;
        logic [15:0] conf;
    } detection_t;

    logic clk, rst_n;
    logic in_valid, in_stall, kind;
    logic signed [15:0] class_logit, dist_left, dist_top, dist_right, dist_bottom, angle;
    logic [8:0] cell_col, cell_row;
    logic [1:0] stride_code;
    logic out_valid, out_stall;
    logic [15:0] center_x, center_y, confidence;
    logic [16:0] box_width, box_height;
    logic signed [15:0] box_angle;
    logic [7:0] class_index;
    logic cfg_valid, cfg_ready;
    logic [obcd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    oriented_box_cell_decode_unit DUT (.*);

    cell_req_t  pending_reqs[$];
    detection_t expected_dets[$];
    int fail_count = 0;

    // predictor state
    logic [15:0] p_thr;
    logic [11:0] p_padl, p_padt;
    logic [15:0] p_inv;
    logic [12:0] p_fw, p_fh;
    logic [7:0]  p_ncls;
    int p_best, p_bcls, p_cnt;
    bit p_seen;

    localparam int SIG_LUT[33] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
        64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514, 65523, 65528, 65531,
        65533, 65534, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535,
        65535};
    localparam int SIN_LUT[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
        12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};

    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int sigmoid16(int x);
        int a, i, fr, s;
        a = x < 0 ? -x : x;
        i = a >> 10;
        fr = a & 1023;
        s = SIG_LUT[i];
        if (i < 32)
            s += ((SIG_LUT[i + 1] - SIG_LUT[i]) * fr) >> 10;
        return x < 0 ? 65536 - s : s;
    endfunction

    function automatic longint quarter_sine(int f);
        int i, fr, v;
        i = f >> 12;
        fr = f & 4095;
        v = SIN_LUT[i];
        if (i < 16)
            v += ((SIN_LUT[i + 1] - SIN_LUT[i]) * fr) >> 12;
        return v;
    endfunction

    function automatic longint phase_sine(int p);
        int q, f;
        longint m;
        p &= 'h3FFFF;
        q = p >> 16;
        f = p & 'hFFFF;
        m = q[0] ? quarter_sine(65536 - f) : quarter_sine(f);
        return q[1] ? -m : m;
    endfunction

    task automatic queue_req(cell_req_t r);
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic write_reg_model(obcd_pkg::cfg_reg_t idx, logic [15:0] v);
        case (idx)
            obcd_pkg::REG_SCORE_THRESHOLD: p_thr = v;
            obcd_pkg::REG_PAD_LEFT:        p_padl = v[11:0];
            obcd_pkg::REG_PAD_TOP:         p_padt = v[11:0];
            obcd_pkg::REG_INVERSE_SCALE:   p_inv = v;
            obcd_pkg::REG_FRAME_WIDTH:     p_fw = v[12:0];
            obcd_pkg::REG_FRAME_HEIGHT:    p_fh = v[12:0];
            obcd_pkg::REG_CLASSES_IN_USE:  p_ncls = v[7:0];
            default: ;
        endcase
    endtask

    task automatic predict_cell(cell_req_t r);
        int conf, lim, ph, col, row;
        longint st, l, t, rr, b, c, s, d, e, rx, ry, px, py, fw, fh, inv;
        bit have;
        detection_t det;
        if (r.kind == obcd_pkg::KIND_LOGIT)
        begin
            lim = p_ncls;
            if (p_cnt < lim)
            begin
                if (!p_seen || $signed(r.logit) > p_best)
                begin
                    p_best = $signed(r.logit);
                    p_bcls = p_cnt;
                end
                p_seen = 1;
                p_cnt++;
            end
            return;
        end
        have = p_seen;
        conf = sigmoid16(p_best);
        p_best = 0;
        p_cnt = 0;
        p_seen = 0;
        if (!have)
            return;
        if (conf < p_thr)
        begin
            p_bcls = 0;
            return;
        end
        st = 8 << (r.sc > 2 ? 2 : r.sc);
        col = r.col;
        row = r.row;
        l = $signed(r.dl);
        t = $signed(r.dt);
        rr = $signed(r.dr);
        b = $signed(r.db);
        inv = p_inv;
        fw = clampl(p_fw, 1, 4096);
        fh = clampl(p_fh, 1, 4096);
        ph = int'(((longint'($signed(r.ang)) * 41722) >>> 13) & 'h3FFFF);
        s = phase_sine(ph);
        c = phase_sine(ph + 65536);
        d = (rr - l) * st;
        e = (b - t) * st;
        rx = rnd_shr(d * c - e * s, 19);
        ry = rnd_shr(d * s + e * c, 19);
        px = (2 * col + 1) * st * 8 + rx - longint'(p_padl) * 16;
        py = (2 * row + 1) * st * 8 + ry - longint'(p_padt) * 16;
        det.cx = 16'(clampl(rnd_shr(px * inv, 12), 0, (fw - 1) * 16));
        det.cy = 16'(clampl(rnd_shr(py * inv, 12), 0, (fh - 1) * 16));
        det.bw = 17'(clampl(rnd_shr((l + rr) * st * inv, 16), 16, fw * 16));
        det.bh = 17'(clampl(rnd_shr((t + b) * st * inv, 16), 16, fh * 16));
        det.ang = r.ang;
        det.cls = 8'(p_bcls);
        det.conf = 16'(conf);
        p_bcls = 0;
        expected_dets = {expected_dets, det};
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    int in_gap = 0;
    bit in_taken = 0;
    cell_req_t cur;

    // records whether the driven request was accepted at this rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur = pending_reqs.pop_front();
                predict_cell(cur);
                {kind, class_logit, dist_left, dist_top, dist_right, dist_bottom, angle,
                 cell_col, cell_row, stride_code} <= cur;
                in_valid <= 1;
                in_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 9));
            end
            else
            begin
                in_valid <= 0;
            end
        end
    end

    // output stall
    int out_hold = 0;
    bit stall_free = 0;
    always @(negedge clk)
    begin
        if (stall_free || out_hold == 0)
        begin
            out_stall <= 0;
            if (out_valid)
                out_hold <= int'($urandom_range(0, 9));
        end
        else
        begin
            out_stall <= 1;
            out_hold <= out_hold - 1;
        end
    end

    // monitor
    detection_t got, exp_det;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = {center_x, center_y, box_width, box_height, box_angle, class_index,
                   confidence};
            if (expected_dets.size() == 0)
            begin
                $error("unexpected detection %p", got);
                fail_count++;
            end
            else
            begin
                exp_det = expected_dets.pop_front();
                if (got.cx !== exp_det.cx)
                begin
                    $error("center_x exp %0d got %0d", exp_det.cx, got.cx);
                    fail_count++;
                end
                if (got.cy !== exp_det.cy)
                begin
                    $error("center_y exp %0d got %0d", exp_det.cy, got.cy);
                    fail_count++;
                end
                if (got.bw !== exp_det.bw)
                begin
                    $error("box_width exp %0d got %0d", exp_det.bw, got.bw);
                    fail_count++;
                end
                if (got.bh !== exp_det.bh)
                begin
                    $error("box_height exp %0d got %0d", exp_det.bh, got.bh);
                    fail_count++;
                end
                if (got.ang !== exp_det.ang)
                begin
                    $error("box_angle exp %0d got %0d", exp_det.ang, got.ang);
                    fail_count++;
                end
                if (got.cls !== exp_det.cls)
                begin
                    $error("class_index exp %0d got %0d", exp_det.cls, got.cls);
                    fail_count++;
                end
                if (got.conf !== exp_det.conf)
                begin
                    $error("confidence exp %0d got %0d", exp_det.conf, got.conf);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_dets.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(obcd_pkg::cfg_reg_t idx, logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        write_reg_model(idx, v);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic cell_req_t rand_req(logic k);
        cell_req_t r;
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        r = bits[$bits(cell_req_t)-1:0];
        r.kind = k;
        if ($urandom_range(0, 3) != 0)
        begin
            // moderate geometry keeps boxes inside the frame often
            r.dl = 16'($urandom_range(0, 2047));
            r.dt = 16'($urandom_range(0, 2047));
            r.dr = 16'($urandom_range(0, 2047));
            r.db = 16'($urandom_range(0, 2047));
            r.col = 9'($urandom_range(0, 40));
            r.row = 9'($urandom_range(0, 40));
        end
        if ($urandom_range(0, 2) != 0)
            r.logit = 16'($signed($urandom_range(0, 16384)) - 4096);
        return r;
    endfunction

    task automatic push_cell(int ncls, int style);
        cell_req_t r;
        for (int i = 0; i < ncls; i++)
        begin
            r = rand_req(obcd_pkg::KIND_LOGIT);
            if (style == 1)
                r.logit = 16'h0800;     // ties: first max wins
            queue_req(r);
        end
        queue_req(rand_req(obcd_pkg::KIND_GEOM));
    endtask

    task automatic rand_cfg(int mode);
        cfg_write(obcd_pkg::REG_SCORE_THRESHOLD, mode == 0 ? 16'd0 : (mode == 1 ? 16'hFFFF :
                  16'($urandom_range(0, 50000))));
        cfg_write(obcd_pkg::REG_PAD_LEFT, mode == 1 ? 16'hFFF : 16'($urandom_range(0, 64)));
        cfg_write(obcd_pkg::REG_PAD_TOP, mode == 1 ? 16'hFFF : 16'($urandom_range(0, 64)));
        cfg_write(obcd_pkg::REG_INVERSE_SCALE, mode == 0 ? 16'd1 : (mode == 1 ? 16'hFFFF :
                  16'($urandom_range(1024, 8192))));
        cfg_write(obcd_pkg::REG_FRAME_WIDTH, mode == 0 ? 16'd1 : (mode == 1 ? 16'd4096 :
                  16'($urandom_range(64, 2048))));
        cfg_write(obcd_pkg::REG_FRAME_HEIGHT, mode == 0 ? 16'd1 : (mode == 1 ? 16'd4096 :
                  16'($urandom_range(64, 2048))));
        cfg_write(obcd_pkg::REG_CLASSES_IN_USE, mode == 0 ? 16'd1 : (mode == 1 ? 16'd255 :
                  16'($urandom_range(1, 20))));
    endtask

    initial
    begin
        cell_req_t r;
        int sent;
        rst_n = 0;
        in_valid = 0;
        {kind, class_logit, dist_left, dist_top, dist_right, dist_bottom, angle,
         cell_col, cell_row, stride_code} = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        p_thr = 16384; p_padl = 0; p_padt = 0; p_inv = 4096;
        p_fw = 640; p_fh = 640; p_ncls = 15;
        p_best = 0; p_bcls = 0; p_cnt = 0; p_seen = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, ties, no-class cell, extra classes, stride three
        cfg_write(obcd_pkg::REG_SCORE_THRESHOLD, 16'd0);
        r = rand_req(obcd_pkg::KIND_GEOM);
        queue_req(r);                               // geometry with no class
        r = '0; r.logit = 16'h7FFF; queue_req(r);
        r.logit = 16'h8000; queue_req(r);
        r = '1; r.kind = obcd_pkg::KIND_GEOM; queue_req(r);
        r = '0; r.logit = 16'h8000; queue_req(r);
        r = '0; r.kind = obcd_pkg::KIND_GEOM; r.dl = 16'h8000; r.dt = 16'h7FFF;
        r.dr = 16'h7FFF; r.db = 16'h8000; r.ang = 16'h8000; r.sc = 2'd3; r.col = 9'h1FF;
        queue_req(r);
        push_cell(3, 1);
        push_cell(18, 0);                           // past classes_in_use
        r = '0; r.logit = 16'h0400; queue_req(r);
        r = rand_req(obcd_pkg::KIND_GEOM); r.ang = 16'h7FFF; queue_req(r);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            rand_cfg(ph < 2 ? ph : 2);
            stall_free = (ph == 3);
            sent = 0;
            while (sent < 250)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    r = rand_req(1'($urandom_range(0, 1)));
                    queue_req(r);
                    sent++;
                end
                else
                begin
                    push_cell($urandom_range(0, 6), $urandom_range(0, 7) == 0);
                    sent += 4;
                end
                if ($urandom_range(0, 40) == 0)
                begin
                    // sender waits for the block to empty
                    while (pending_reqs.size() > 0 || in_valid || expected_dets.size() > 0)
                        @(posedge clk);
                end
            end
            wait_drained();
        end
        if (fail_count == 0)
            $display("oriented_box_cell_decode_unit regression: pass");
        else
            $display("oriented_box_cell_decode_unit regression: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("oriented_box_cell_decode_unit regression: fail");
        $finish;
    end

endmodule
